@@ hdl/qpe_pkg.sv @@
// Shared types, token kind codes and controller/datapath interface structs.
package qpe_pkg;

   localparam int VALUE_W = 32;
   localparam int KIND_W  = 3;
   localparam int TOKEN_W = KIND_W + VALUE_W;

   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [VALUE_W-1:0] value_type;

   // Token kind codes; kinds above divide behave as operands.
   localparam kind_type KIND_VALUE = 3'd0;
   localparam kind_type KIND_ADD   = 3'd1;
   localparam kind_type KIND_SUB   = 3'd2;
   localparam kind_type KIND_MUL   = 3'd3;
   localparam kind_type KIND_DIV   = 3'd4;

   // Source of a token appended at the queue tail.
   typedef enum logic [2:0] {
      APP_NONE,
      APP_INPUT,
      APP_HELD_OP,
      APP_FIRST,
      APP_RESULT,
      APP_TOKEN
   } app_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      app_sel_type app_sel;
      logic        rd_req;
      logic        rd_inc;
      logic        hold_op;
      logic        take_first;
      logic        start_exec;
      logic        latch_div;
      logic        finish_apply;
      logic        set_bad;
      logic        clear_all;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic wr_full;
      logic empty;
      logic tok_is_op;
      logic held_vld;
      logic held_is_div;
      logic first_vld;
      logic applied;
      logic div_done;
   } status_type;

   function automatic logic is_operator(input kind_type kind);
      return (kind >= KIND_ADD) && (kind <= KIND_DIV);
   endfunction

endpackage

@@ hdl/qpe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module qpe_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/qpe_divider.sv @@
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating toward zero.
module qpe_divider
   import qpe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  value_type dividend,
   input  value_type divisor,
   output logic      done,
   output value_type quotient,
   output logic      div_zero
);

   logic                busy_ff;
   logic                done_ff;
   logic [4:0]          cnt_ff;
   value_type           rem_ff;
   value_type           quo_ff;
   value_type           dvs_ff;
   logic                neg_ff;
   logic                zero_ff;
   logic [VALUE_W:0]    shifted;
   logic [VALUE_W:0]    diff;
   value_type           rem_in;
   value_type           quo_in;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[VALUE_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (!diff[VALUE_W]) begin
         rem_in = diff[VALUE_W-1:0];
         quo_in = {quo_ff[VALUE_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[VALUE_W-1:0];
         quo_in = {quo_ff[VALUE_W-2:0], 1'b0};
      end
   end

   // Control and operand registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // Completion follows a zero divisor at once, or the last iteration.
         done_ff <= (start && (divisor == '0)) ||
                    (!start && busy_ff && (cnt_ff == 5'd31));
         if (start) begin
            if (divisor == '0) begin
               zero_ff <= 1'b1;
               quo_ff  <= '0;
               neg_ff  <= 1'b0;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= '0;
               zero_ff <= 1'b0;
               rem_ff  <= '0;
               quo_ff  <= dividend[VALUE_W-1] ? -dividend : dividend;
               dvs_ff  <= divisor[VALUE_W-1] ? -divisor : divisor;
               neg_ff  <= dividend[VALUE_W-1] ^ divisor[VALUE_W-1];
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;
   assign div_zero = zero_ff;

   // Completion is a single-cycle pulse.
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

   // A running division never reports completion in the same cycle.
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> !done_ff)
      else $error("divider done while still iterating");

   // A zero divisor completes on the next cycle and is flagged.
   assert property (@(posedge clock) disable iff (reset)
                    (start && (divisor == '0)) |=> (done_ff && zero_ff))
      else $error("zero divisor not reported on the next cycle");

endmodule

@@ hdl/qpe_datapath.sv @@
// Token queue, pointers, held operator and operand, ALU, divider and flags.
module qpe_datapath
   import qpe_pkg::*;
#(
   parameter int QUEUE_SLOTS = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  kind_type   in_kind,
   input  value_type  in_value,
   output value_type  result_value,
   output logic       div_by_zero,
   output logic       malformed
);

   localparam int ADDR_W = $clog2(QUEUE_SLOTS);
   localparam int PTR_W  = $clog2(QUEUE_SLOTS + 1);

   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   kind_type           held_ff;
   value_type          first_ff;
   logic               first_vld_ff;
   logic               applied_ff;
   logic               div0_ff;
   logic               bad_ff;
   value_type          result_ff;

   logic               wr_full;
   logic               ram_we;
   logic [TOKEN_W-1:0] ram_wdata;
   logic [TOKEN_W-1:0] ram_rdata;
   kind_type           tok_kind;
   value_type          tok_val;
   value_type          alu_out;
   logic [2*VALUE_W-1:0] product;
   logic               div_start;
   logic               div_done;
   value_type          div_q;
   logic               div_zero;

   assign wr_full  = (wr_ptr_ff == PTR_W'(QUEUE_SLOTS));
   assign tok_kind = ram_rdata[TOKEN_W-1:VALUE_W];
   assign tok_val  = ram_rdata[VALUE_W-1:0];

   // Tail append source; appends at a full queue are dropped.
   always_comb begin
      case (cmd.app_sel)
         APP_INPUT:   ram_wdata = {in_kind, in_value};
         APP_HELD_OP: ram_wdata = {held_ff, value_type'(0)};
         APP_FIRST:   ram_wdata = {KIND_VALUE, first_ff};
         APP_RESULT:  ram_wdata = {KIND_VALUE, result_ff};
         APP_TOKEN:   ram_wdata = {tok_kind, tok_val};
         default:     ram_wdata = '0;
      endcase
   end
   assign ram_we = (cmd.app_sel != APP_NONE) && !wr_full;

   qpe_ram #(
      .WIDTH(TOKEN_W),
      .DEPTH(QUEUE_SLOTS)
   ) u_queue (
      .clock(clock),
      .we   (ram_we),
      .waddr(wr_ptr_ff[ADDR_W-1:0]),
      .wdata(ram_wdata),
      .re   (cmd.rd_req),
      .raddr(rd_ptr_ff[ADDR_W-1:0]),
      .rdata(ram_rdata)
   );

   // Combinational add, subtract and low half of the product.
   assign product = first_ff * tok_val;
   always_comb begin
      case (held_ff)
         KIND_ADD: alu_out = first_ff + tok_val;
         KIND_SUB: alu_out = first_ff - tok_val;
         KIND_MUL: alu_out = product[VALUE_W-1:0];
         default:  alu_out = '0;
      endcase
   end

   assign div_start = cmd.start_exec && (held_ff == KIND_DIV);

   qpe_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(first_ff),
      .divisor (tok_val),
      .done    (div_done),
      .quotient(div_q),
      .div_zero(div_zero)
   );

   // Evaluation state registers.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         held_ff      <= KIND_VALUE;
         first_ff     <= '0;
         first_vld_ff <= 1'b0;
         applied_ff   <= 1'b0;
         div0_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         result_ff    <= '0;
      end else begin
         if (ram_we) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (cmd.rd_inc) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (cmd.hold_op) begin
            held_ff      <= tok_kind;
            first_vld_ff <= 1'b0;
            applied_ff   <= 1'b0;
         end
         if (cmd.take_first) begin
            first_ff     <= tok_val;
            first_vld_ff <= 1'b1;
         end
         if (cmd.start_exec && (held_ff != KIND_DIV)) begin
            result_ff <= alu_out;
         end
         if (cmd.latch_div) begin
            result_ff <= div_q;
            if (div_zero) begin
               div0_ff <= 1'b1;
            end
         end
         if (cmd.finish_apply) begin
            held_ff      <= KIND_VALUE;
            first_vld_ff <= 1'b0;
            applied_ff   <= 1'b1;
         end
         if (cmd.set_bad) begin
            bad_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      status.wr_full     = wr_full;
      status.empty       = (rd_ptr_ff == wr_ptr_ff);
      status.tok_is_op   = is_operator(tok_kind);
      status.held_vld    = (held_ff != KIND_VALUE);
      status.held_is_div = (held_ff == KIND_DIV);
      status.first_vld   = first_vld_ff;
      status.applied     = applied_ff;
      status.div_done    = div_done;
   end

   assign result_value = result_ff;
   assign div_by_zero  = div0_ff;
   assign malformed    = bad_ff;

   // The walk never reads past the tail.
   assert property (@(posedge clock) disable iff (reset) rd_ptr_ff <= wr_ptr_ff)
      else $error("read pointer passed write pointer");

   // The tail never runs beyond capacity.
   assert property (@(posedge clock) disable iff (reset)
                    wr_ptr_ff <= PTR_W'(QUEUE_SLOTS))
      else $error("write pointer beyond queue capacity");

   // A first operand is only ever held under an operator.
   assert property (@(posedge clock) disable iff (reset)
                    first_vld_ff |-> (held_ff != KIND_VALUE))
      else $error("first operand held without an operator");

endmodule

@@ hdl/qpe_ctrl.sv @@
// Controller state machine: token loading, queue walk sequencing and result handshake.
module qpe_ctrl
   import qpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_READ,
      S_DECIDE,
      S_OP_FIRST,
      S_DIV_WAIT,
      S_APPLY,
      S_OUTPUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.app_sel = APP_NONE;
      unique case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               cmd.app_sel = APP_INPUT;
               if (req_tlast) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // The walk ends once the tail reaches capacity.
            if (status.wr_full) begin
               state_in = S_OUTPUT;
            end else if (status.empty) begin
               cmd.set_bad = 1'b1;
               state_in    = S_OUTPUT;
            end else begin
               cmd.rd_req = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.tok_is_op) begin
               // Requeue a held operator, then the held operand next cycle.
               if (status.held_vld) begin
                  cmd.app_sel = APP_HELD_OP;
               end
               state_in = S_OP_FIRST;
            end else if (status.held_vld && !status.first_vld) begin
               cmd.take_first = 1'b1;
               cmd.rd_inc     = 1'b1;
               state_in       = S_READ;
            end else if (status.held_vld) begin
               cmd.start_exec = 1'b1;
               cmd.rd_inc     = 1'b1;
               state_in       = status.held_is_div ? S_DIV_WAIT : S_APPLY;
            end else if (status.applied) begin
               // Lone value after a reduction rotates to the tail.
               cmd.app_sel = APP_TOKEN;
               cmd.rd_inc  = 1'b1;
               state_in    = S_READ;
            end else begin
               cmd.set_bad = 1'b1;
               state_in    = S_OUTPUT;
            end
         end
         S_OP_FIRST: begin
            if (status.first_vld) begin
               cmd.app_sel = APP_FIRST;
            end
            cmd.hold_op = 1'b1;
            cmd.rd_inc  = 1'b1;
            state_in    = S_READ;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.latch_div = 1'b1;
               state_in      = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.app_sel      = APP_RESULT;
            cmd.finish_apply = 1'b1;
            state_in         = S_READ;
         end
         S_OUTPUT: begin
            if (rsp_tready) begin
               cmd.clear_all = 1'b1;
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = (state_ff == S_OUTPUT);

   // Loading and result delivery never overlap.
   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid))
      else $error("request and response sides active together");

   // A division reduction always waits for the divider.
   assert property (@(posedge clock) disable iff (reset)
                    (cmd.start_exec && status.held_is_div) |=> (state_ff == S_DIV_WAIT))
      else $error("division started without waiting for the divider");

   // A stalled response stays offered until the receiver takes it.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response withdrawn before it was taken");

endmodule

@@ hdl/queue_prefix_expression_evaluator.sv @@
// Top level of the prefix expression evaluator: controller, datapath and stream ports.
//
// Usage: tokens of a prefix integer expression arrive on the req_ channel, one
// request per token: req_tuser carries the token kind (0 operand, 1 add,
// 2 subtract, 3 multiply, 4 divide; 5 to 7 act as operands), req_tdata the
// signed operand and req_tlast marks the final token. Tokens are taken one
// per cycle and appended to a queue of QUEUE_SLOTS entries; tokens arriving
// at a full queue are dropped. After the last token the block walks the queue
// and accepts no request until its single response has been taken.
// A division by a nonzero divisor waits while the divider yields one
// quotient bit a cycle; a zero divisor ends the division without iterating.
// The walk runs until the tail reaches QUEUE_SLOTS or the expression is
// found malformed, so its length grows with QUEUE_SLOTS.
// The response carries the last reduced value on rsp_tdata and the
// division-by-zero and malformed flags on rsp_tuser; it holds while
// rsp_tready is low. Reset empties the queue and returns to token loading;
// no clearing pass is needed.
module queue_prefix_expression_evaluator
   import qpe_pkg::*;
#(
   parameter int QUEUE_SLOTS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand_value
   input  logic [2:0]  req_tuser,   // [2:0] func
   input  logic        req_tlast,   // last_token
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_value
   output logic [1:0]  rsp_tuser    // [0] div_by_zero, [1] malformed
);

   cmd_type    cmd;
   status_type status;
   value_type  result_value;
   logic       div_by_zero;
   logic       malformed;

   qpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tlast (req_tlast),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   qpe_datapath #(
      .QUEUE_SLOTS(QUEUE_SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_kind     (req_tuser),
      .in_value    (req_tdata),
      .result_value(result_value),
      .div_by_zero (div_by_zero),
      .malformed   (malformed)
   );

   assign rsp_tdata = result_value;
   assign rsp_tuser = {malformed, div_by_zero};

endmodule

@@ tb/queue_prefix_expression_evaluator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the prefix expression evaluator, with its own token-queue predictor.
module queue_prefix_expression_evaluator_tb
   import qpe_pkg::*;
();

   localparam int        SLOTS        = 128;
   localparam int        QUIET_LIMIT  = 20000;
   localparam int        PHASE_TOKENS = 210;
   localparam int        SHOW_LIMIT   = 10;
   localparam value_type INT_MIN      = 32'h8000_0000;
   localparam value_type INT_MAX      = 32'h7FFF_FFFF;
   // Kind codes above divide are not operators and travel as plain operands.
   localparam kind_type  KIND_SPARE_LO = 3'd5;
   localparam kind_type  KIND_SPARE_HI = 3'd7;

   typedef struct {
      kind_type  kind;
      value_type value;
   } token_type;

   typedef struct {
      value_type value;
      logic      div_zero;
      logic      stalled;
   } outcome_type;

   // Predicts the evaluator from accepted requests and checks its responses.
   class eval_scoreboard;
      kind_type    slot_kind[SLOTS];
      value_type   slot_value[SLOTS];
      int unsigned rd_ptr, wr_ptr;
      kind_type    held_op;
      value_type   first_val, last_value;
      bit          first_held, reduced, div_zero, stalled;
      outcome_type awaited_results[$];
      int unsigned error_count, checked_count, div_zero_count, stalled_count;

      function new();
         restart();
      endfunction

      function void restart();
         rd_ptr     = 0;
         wr_ptr     = 0;
         held_op    = KIND_VALUE;
         first_val  = '0;
         last_value = '0;
         first_held = 0;
         reduced    = 0;
         div_zero   = 0;
         stalled    = 0;
      endfunction

      // Appends at the tail; a full queue silently drops the token.
      function void push_tail(kind_type kind, value_type value);
         if (wr_ptr < SLOTS) begin
            slot_kind[wr_ptr]  = kind;
            slot_value[wr_ptr] = value;
            wr_ptr++;
         end
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction

      // Takes one accepted request; the last token triggers the whole walk.
      function void take_token(kind_type kind, value_type value, logic is_last);
         kind_type    k;
         value_type   v;
         outcome_type outcome;
         push_tail(kind, value);
         if (!is_last)
            return;
         // Walk until the tail reaches capacity, or stop on a stall or an empty queue.
         while (wr_ptr < SLOTS) begin
            if (rd_ptr >= wr_ptr) begin
               stalled = 1;
               break;
            end
            k = slot_kind[rd_ptr];
            v = slot_value[rd_ptr];
            if (k >= KIND_ADD && k <= KIND_DIV) begin
               // A new operator sends the held operator and operand back to the tail.
               if (held_op != KIND_VALUE)
                  push_tail(held_op, '0);
               if (first_held) begin
                  push_tail(KIND_VALUE, first_val);
                  first_held = 0;
               end
               held_op = k;
               rd_ptr++;
               reduced = 0;
            end else if (held_op != KIND_VALUE && !first_held) begin
               first_val  = v;
               first_held = 1;
               rd_ptr++;
            end else if (held_op != KIND_VALUE) begin
               rd_ptr++;
               case (held_op)
                  KIND_ADD: last_value = first_val + v;
                  KIND_SUB: last_value = first_val - v;
                  KIND_MUL: last_value = first_val * v;
                  KIND_DIV: begin
                     if (v == '0) begin
                        last_value = '0;
                        div_zero   = 1;
                     end else if (first_val == INT_MIN && v == '1) begin
                        last_value = INT_MIN;
                     end else begin
                        last_value = value_type'($signed(first_val) / $signed(v));
                     end
                  end
                  default: ;
               endcase
               push_tail(KIND_VALUE, last_value);
               held_op    = KIND_VALUE;
               first_held = 0;
               reduced    = 1;
            end else if (reduced) begin
               // Lone value after a reduction is rotated to the tail.
               rd_ptr++;
               push_tail(k, v);
            end else begin
               stalled = 1;
               break;
            end
         end
         outcome.value    = last_value;
         outcome.div_zero = div_zero;
         outcome.stalled  = stalled;
         awaited_results.push_back(outcome);
         restart();
      endfunction

      function void check_result(value_type value, logic [1:0] flags);
         outcome_type want;
         checked_count++;
         if (awaited_results.size() == 0) begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
               $display("ERROR: unexpected response value=%0d flags=%b",
                        $signed(value), flags);
            return;
         end
         want = awaited_results.pop_front();
         if (want.div_zero)
            div_zero_count++;
         if (want.stalled)
            stalled_count++;
         if (value !== want.value || flags[0] !== want.div_zero || flags[1] !== want.stalled)
         begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
               $display({"ERROR: response %0d: expected value=%0d div0=%b malformed=%b,",
                         " got value=%0d div0=%b malformed=%b"},
                        checked_count, $signed(want.value), want.div_zero, want.stalled,
                        $signed(value), flags[0], flags[1]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   eval_scoreboard sb = new();
   token_type      expr_tokens[$];
   int unsigned    send_idle_pct  = 0;
   int unsigned    recv_stall_pct = 0;
   int unsigned    tokens_sent    = 0;
   int unsigned    quiet_cycles   = 0;

   queue_prefix_expression_evaluator #(.QUEUE_SLOTS(SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] operand_value
      .req_tuser  (req_tuser),   // [2:0] func
      .req_tlast  (req_tlast),   // last_token
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] result_value
      .rsp_tuser  (rsp_tuser)    // [0] div_by_zero, [1] malformed
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver stalls at random, changing only on the falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Both channels are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.take_token(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog on cycles in which neither channel moves a request.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
         $display("queue_prefix_expression_evaluator_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic value_type pick_operand();
      value_type v;
      case ($urandom_range(9))
         0: v = '0;
         1: v = 32'd1;
         2: v = '1;
         3: v = INT_MIN;
         4: v = INT_MAX;
         5, 6: begin
            v = $urandom_range(18);
            v = v - 9;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic void queue_token(kind_type kind, value_type value);
      token_type t;
      t.kind  = kind;
      t.value = value;
      expr_tokens.push_back(t);
   endfunction

   function automatic void add_operand();
      if ($urandom_range(99) < 15)
         queue_token(kind_type'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), pick_operand());
      else
         queue_token(KIND_VALUE, pick_operand());
   endfunction

   // Builds a random well-formed prefix subtree of at most the given depth.
   function automatic void grow_expression(int depth);
      if (depth > 0 && $urandom_range(99) < 60) begin
         queue_token(kind_type'($urandom_range(KIND_ADD, KIND_DIV)), $urandom);
         grow_expression(depth - 1);
         grow_expression(depth - 1);
      end else begin
         add_operand();
      end
   endfunction

   // Drives one token from a falling edge; ends right after the rising edge that takes it.
   task automatic send_token(kind_type kind, value_type value, logic is_last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      tokens_sent++;
   endtask

   task automatic send_expression();
      foreach (expr_tokens[i])
         send_token(expr_tokens[i].kind, expr_tokens[i].value, i == expr_tokens.size() - 1);
      expr_tokens.delete();
   endtask

   // Hold the sender off until every awaited response has been taken.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned phase_end;
      int unsigned pick;
      int unsigned count;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: wraparound at the extremes.
      queue_token(KIND_ADD, $urandom);
      queue_token(KIND_VALUE, INT_MAX);
      queue_token(KIND_VALUE, 32'd1);
      send_expression();
      queue_token(KIND_SUB, $urandom);
      queue_token(KIND_VALUE, INT_MIN);
      queue_token(KIND_VALUE, 32'd1);
      send_expression();
      queue_token(KIND_MUL, $urandom);
      queue_token(KIND_VALUE, INT_MIN);
      queue_token(KIND_VALUE, '1);
      send_expression();
      // Division overflow, division by zero and truncation toward zero.
      queue_token(KIND_DIV, $urandom);
      queue_token(KIND_VALUE, INT_MIN);
      queue_token(KIND_VALUE, '1);
      send_expression();
      queue_token(KIND_DIV, '0);
      queue_token(KIND_VALUE, 32'd7);
      queue_token(KIND_VALUE, '0);
      send_expression();
      queue_token(KIND_DIV, '1);
      queue_token(KIND_VALUE, -32'sd7);
      queue_token(KIND_SPARE_LO, 32'd2);
      send_expression();
      // A value with nothing held, using a spare kind code.
      queue_token(KIND_SPARE_HI, 32'd5);
      send_expression();
      // The queue runs empty with an operand still missing.
      queue_token(KIND_ADD, '0);
      queue_token(KIND_VALUE, 32'd3);
      send_expression();
      // Nested operator forces re-queueing and rotation of a lone value.
      queue_token(KIND_ADD, '0);
      queue_token(KIND_MUL, '0);
      queue_token(KIND_VALUE, 32'd2);
      queue_token(KIND_VALUE, 32'd3);
      queue_token(KIND_VALUE, 32'd4);
      send_expression();
      // Overfill the queue on load: trailing tokens are dropped.
      queue_token(KIND_ADD, '0);
      repeat (SLOTS + 2)
         queue_token(KIND_VALUE, $urandom);
      send_expression();
      drain_results();

      // Random expressions over four idling profiles.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         phase_end = tokens_sent + PHASE_TOKENS;
         while (tokens_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               grow_expression($urandom_range(1, 4));
            end else if (pick < 83) begin
               // Truncated expression.
               grow_expression($urandom_range(2, 4));
               count = $urandom_range(1, 2);
               while (count > 0 && expr_tokens.size() > 1) begin
                  void'(expr_tokens.pop_back());
                  count--;
               end
            end else if (pick < 89) begin
               // A value ahead of an otherwise valid expression.
               add_operand();
               grow_expression($urandom_range(1, 3));
            end else if (pick < 95) begin
               repeat ($urandom_range(1, 8))
                  queue_token(kind_type'($urandom_range(0, 7)), $urandom);
            end else begin
               queue_token(kind_type'($urandom_range(0, 7)), pick_operand());
            end
            send_expression();
         end
         drain_results();
      end

      repeat (60) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.error_count++;
         $display("ERROR: %0d responses never arrived", sb.pending());
      end
      $display("Sent %0d tokens over four idling profiles; checked %0d responses,",
               tokens_sent, sb.checked_count);
      $display("%0d of them with divide by zero and %0d malformed.",
               sb.div_zero_count, sb.stalled_count);
      if (sb.error_count == 0)
         $display("queue_prefix_expression_evaluator_tb: clean");
      else
         $display("queue_prefix_expression_evaluator_tb: errors");
      $finish;
   end

endmodule
